// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/tsch_pkg.sv -----
// Task scheduler package: codes, widths and controller/datapath structs.
// No dependencies.
package tsch_pkg;

  localparam int SLOT_W = 4;
  localparam int DEF_NUM_SLOTS = 16;

  localparam logic [1:0] KIND_EXEC   = 2'd0;
  localparam logic [1:0] KIND_FORK   = 2'd1;
  localparam logic [1:0] KIND_PICK   = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_FAIR = 2'd1;
  localparam logic [1:0] POL_FCFS = 2'd2;
  localparam logic [1:0] POL_SJF  = 2'd3;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_SLEEP = 2'd2;

  localparam logic [1:0] RAN_SLEEP = 2'd1;
  localparam logic [1:0] RAN_EXIT  = 2'd2;

  typedef struct packed {
    logic load_item;
    logic idx_inc;
    logic exec_wr;
    logic fork_fail;
    logic fork_copy;
    logic div_start;
    logic pick_eval;
    logic pick_commit;
    logic rep_cur;
    logic rep_other;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       idx_last;
    logic       slot_free;
    logic       need_div;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

// ----- rtl/core/multi_policy_task_scheduler.sv -----
// Multi-policy task scheduler: takes one word at a time and walks the slot
// table one entry per cycle, except that a pick under the fair policy holds on
// each running slot that needs a ratio while the one serial divider runs. The
// next word is taken while the previous result waits at the output.
module multi_policy_task_scheduler import tsch_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [SLOT_W-1:0] src_slot,
  input  logic              has_job,
  input  logic [15:0]       job_len,
  input  logic [1:0]        ran_state,
  input  logic [15:0]       ran_time,
  input  logic [15:0]       nap_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] chosen_slot,
  output logic              first_run,
  output logic              status
);

  cmd_t cmd;
  sts_t sts;

  tsch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsch_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .kind        (kind),
    .slot        (slot),
    .src_slot    (src_slot),
    .has_job     (has_job),
    .job_len     (job_len),
    .ran_state   (ran_state),
    .ran_time    (ran_time),
    .nap_time    (nap_time),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .chosen_slot (chosen_slot),
    .first_run   (first_run),
    .status      (status)
  );

endmodule

// ----- rtl/core/tsch_div.sv -----
// Restoring 32-bit divider, one quotient bit per cycle.
// Depends on nothing.
module tsch_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, quot[31]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= shifted[31:0];
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/tsch_ctrl.sv -----
// Scheduler sequencer: walks the slot table one entry a cycle per item, holding on an entry while the divider runs.
// Depends on tsch_pkg.
module tsch_ctrl import tsch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_EXEC   = 10'b0000000010,
    S_FSCAN  = 10'b0000000100,
    S_FCOPY  = 10'b0000001000,
    S_PSCAN  = 10'b0000010000,
    S_PDIV   = 10'b0000100000,
    S_PCOMM  = 10'b0001000000,
    S_RCUR   = 10'b0010000000,
    S_RSCAN  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (sts.kind)
            KIND_EXEC: state_next = S_EXEC;
            KIND_FORK: state_next = S_FSCAN;
            KIND_PICK: state_next = S_PSCAN;
            default:   state_next = S_RCUR;
          endcase
        end
      end
      S_EXEC: begin
        cmd.exec_wr = 1'b1;
        state_next = S_DONE;
      end
      S_FSCAN: begin
        if (sts.slot_free) begin
          state_next = S_FCOPY;
        end else if (sts.idx_last) begin
          cmd.fork_fail = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FCOPY: begin
        cmd.fork_copy = 1'b1;
        state_next = S_DONE;
      end
      S_PSCAN: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_PDIV;
        end else begin
          cmd.pick_eval = 1'b1;
          if (sts.idx_last) state_next = S_PCOMM;
          else cmd.idx_inc = 1'b1;
        end
      end
      S_PDIV: begin
        if (sts.div_done) begin
          cmd.pick_eval = 1'b1;
          if (sts.idx_last) begin
            state_next = S_PCOMM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = S_PSCAN;
          end
        end
      end
      S_PCOMM: begin
        cmd.pick_commit = 1'b1;
        state_next = S_DONE;
      end
      S_RCUR: begin
        cmd.rep_cur = 1'b1;
        state_next = S_RSCAN;
      end
      S_RSCAN: begin
        cmd.rep_other = 1'b1;
        if (sts.idx_last) state_next = S_DONE;
        else cmd.idx_inc = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- rtl/core/tsch_dp.sv -----
// Scheduler datapath: slot table, scan index, selection registers, output word.
// Depends on tsch_pkg and tsch_div.
module tsch_dp import tsch_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic [1:0]        kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [SLOT_W-1:0] src_slot,
  input  logic              has_job,
  input  logic [15:0]       job_len,
  input  logic [1:0]        ran_state,
  input  logic [15:0]       ran_time,
  input  logic [15:0]       nap_time,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] chosen_slot,
  output logic              first_run,
  output logic              status
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int XW = IW + SLOT_W;

  logic [1:0]  policy;
  logic [1:0]  st  [NUM_SLOTS];
  logic        hj  [NUM_SLOTS];
  logic [15:0] len [NUM_SLOTS];
  logic [31:0] tot [NUM_SLOTS];
  logic [31:0] wt  [NUM_SLOTS];
  logic [15:0] sl  [NUM_SLOTS];
  logic [15:0] pc  [NUM_SLOTS];
  logic [IW-1:0] cur;

  logic [1:0]  r_kind, r_ran_state;
  logic [XW-1:0] r_slot, r_src;
  logic        r_has_job;
  logic [15:0] r_job_len, r_ran_time, r_nap_time;

  logic [IW-1:0] idx, fdst, pick, rr_hi, rr_lo;
  logic        have, rr_hi_f, rr_lo_f;
  logic [31:0] best;
  logic [IW-1:0] res_chosen;
  logic        res_first, res_status;

  logic        div_done;
  logic [31:0] quot;

  logic [1:0]  st_i;
  logic [31:0] tot_i, wt_i;
  logic [32:0] tot_sum;
  logic [31:0] tot_new;
  logic        retire;
  logic [32:0] wt_sum;
  logic [IW-1:0] n_sel;
  logic [IW-1:0] slot_i, src_i;
  logic        slot_ok, src_ok;

  function automatic logic [SLOT_W-1:0] low4(input logic [IW-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    return x[SLOT_W-1:0];
  endfunction

  assign st_i   = st[idx];
  assign tot_i  = tot[idx];
  assign wt_i   = wt[idx];
  assign slot_i = r_slot[IW-1:0];
  assign src_i  = r_src[IW-1:0];
  assign slot_ok = r_slot < XW'(NUM_SLOTS);
  assign src_ok  = r_src < XW'(NUM_SLOTS);

  assign tot_sum = {1'b0, tot[cur]} + 33'(r_ran_time);
  assign tot_new = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
  assign retire  = (r_ran_state >= RAN_EXIT) ||
                   (hj[cur] && (tot_new >= 32'(len[cur])));
  assign wt_sum  = {1'b0, wt_i} + 33'(r_ran_time);

  always_comb begin
    if (policy == POL_RR) n_sel = rr_hi_f ? rr_hi : (rr_lo_f ? rr_lo : cur);
    else n_sel = pick;
  end

  assign sts.kind      = kind;
  assign sts.idx_last  = (idx == IW'(NUM_SLOTS - 1));
  assign sts.slot_free = (st_i == ST_NONE);
  assign sts.need_div  = (policy == POL_FAIR) && (st_i == ST_RUN) &&
                         (tot_i != '0) && (wt_i != '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

  tsch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tot_i),
    .divisor  (wt_i),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_RR;
    end else if (cfg_we) begin
      policy <= cfg_wdata;
    end
  end

  // item capture and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      r_kind      <= kind;
      r_slot      <= XW'(slot);
      r_src       <= XW'(src_slot);
      r_has_job   <= has_job;
      r_job_len   <= job_len;
      r_ran_state <= ran_state;
      r_ran_time  <= ran_time;
      r_nap_time  <= nap_time;
      idx         <= '0;
      have        <= 1'b0;
      best        <= '0;
      pick        <= cur;
      rr_hi_f     <= 1'b0;
      rr_lo_f     <= 1'b0;
      res_chosen  <= cur;
      res_first   <= 1'b0;
      res_status  <= 1'b0;
    end else begin
      if (cmd.idx_inc) idx <= idx + IW'(1);
      if (cmd.fork_fail) res_status <= 1'b1;
      if (cmd.fork_copy) begin
        if (src_ok) res_chosen <= idx;
        else res_status <= 1'b1;
      end
      if (cmd.pick_eval) begin
        case (policy)
          POL_RR: begin
            if (st_i == ST_RUN) begin
              if (idx > cur && !rr_hi_f) begin
                rr_hi_f <= 1'b1;
                rr_hi   <= idx;
              end
              if (idx < cur && !rr_lo_f) begin
                rr_lo_f <= 1'b1;
                rr_lo   <= idx;
              end
            end
          end
          POL_FAIR: begin
            if (st_i == ST_RUN) begin
              if (tot_i == '0) begin
                have <= 1'b1;
                best <= '0;
                pick <= idx;
              end else if (wt_i == '0) begin
                if (!have) pick <= idx;
              end else if (!have || quot < best) begin
                have <= 1'b1;
                best <= quot;
                pick <= idx;
              end
            end
          end
          POL_FCFS: begin
            if (!hj[cur] && st_i == ST_RUN && idx != IW'(1) && !have) begin
              have <= 1'b1;
              pick <= idx;
            end
          end
          default: begin
            if (st_i == ST_RUN && hj[idx] && (!have || len[idx] < best[15:0])) begin
              have <= 1'b1;
              best <= 32'(len[idx]);
              pick <= idx;
            end
          end
        endcase
      end
      if (cmd.pick_commit) begin
        res_chosen <= n_sel;
        res_first  <= (pc[n_sel] == 16'd0);
      end
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        st[k]  <= (k == 1) ? ST_RUN : ST_NONE;
        hj[k]  <= 1'b0;
        len[k] <= '0;
        tot[k] <= '0;
        wt[k]  <= '0;
        sl[k]  <= '0;
        pc[k]  <= '0;
      end
      cur <= IW'(1);
    end else begin
      if (cmd.exec_wr && slot_ok) begin
        st[slot_i]  <= ST_RUN;
        hj[slot_i]  <= r_has_job;
        len[slot_i] <= r_job_len;
        tot[slot_i] <= '0;
        wt[slot_i]  <= '0;
        sl[slot_i]  <= '0;
        pc[slot_i]  <= '0;
      end
      if (cmd.fork_copy && src_ok) begin
        st[idx]  <= st[src_i];
        hj[idx]  <= hj[src_i];
        len[idx] <= len[src_i];
        tot[idx] <= tot[src_i];
        wt[idx]  <= wt[src_i];
        sl[idx]  <= sl[src_i];
        pc[idx]  <= pc[src_i];
      end
      if (cmd.pick_commit) begin
        cur <= n_sel;
        wt[n_sel] <= '0;
        if (pc[n_sel] != 16'hFFFF) pc[n_sel] <= pc[n_sel] + 16'd1;
      end
      if (cmd.rep_cur) begin
        tot[cur] <= tot_new;
        sl[cur]  <= r_nap_time;
        if (retire) st[cur] <= ST_NONE;
        else if (r_ran_state == RAN_SLEEP) st[cur] <= ST_SLEEP;
        else st[cur] <= ST_RUN;
      end
      if (cmd.rep_other && idx != cur) begin
        if (st_i == ST_RUN) begin
          wt[idx] <= wt_sum[32] ? 32'hFFFF_FFFF : wt_sum[31:0];
        end else if (st_i == ST_SLEEP) begin
          if (sl[idx] <= r_ran_time) begin
            sl[idx] <= '0;
            st[idx] <= ST_RUN;
          end else begin
            sl[idx] <= sl[idx] - r_ran_time;
          end
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      chosen_slot <= (r_kind == KIND_PICK || r_kind == KIND_FORK) ?
                     low4(res_chosen) : low4(cur);
      first_run   <= res_first;
      status      <= res_status;
    end
  end

endmodule

// ----- rtl/core/tsch_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
// Depends on assert_macros.svh and tsch_pkg.
`include "assert_macros.svh"
module tsch_checker import tsch_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] chosen_slot,
  input logic              first_run,
  input logic              status
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLIES(a_fail_not_first, clk, rst, out_valid, !(status && first_run))

endmodule

bind multi_policy_task_scheduler tsch_checker u_chk (.*);
